// ===== hw/rtl/rce_pkg.sv =====
// record code encoder package: shared types, constants and lookup functions
// depends on nothing; used by the serializer, the top level and the testbench

package rce_pkg;

  localparam int unsigned CodeLen   = 16;
  localparam int unsigned SymW      = 5;
  localparam int unsigned LetterW   = 7;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  XOR_SEED  = 8'hC3;
  localparam logic [23:0] TIME_LIMIT = 24'd240000;
  localparam logic [13:0] KC_LIMIT  = 14'h200;
  localparam logic [23:0] MS_PER_MIN = 24'd60000;
  localparam logic [17:0] MS_PER_SEC = 18'd1000;
  localparam logic [13:0] KART_MULT = 14'd37;

  // letter alphabet, first letter in the top byte
  localparam logic [255:0] SYM_LETTERS = "S7LCX3JZE8FG4HBKWN52YPA6RTU9VMDQ";

  localparam logic [5:0] COURSE_TAB [32] = '{
    6'd20, 6'd22, 6'd31, 6'd18, 6'd27, 6'd28, 6'd33, 6'd24,
    6'd30, 6'd17, 6'd25, 6'd19, 6'd34, 6'd26, 6'd32, 6'd29,
    6'd10, 6'd11, 6'd13, 6'd14, 6'd35, 6'd16, 6'd12, 6'd9,
    6'd15, 6'd36, 6'd37, 6'd38, 6'd39, 6'd23, 6'd40, 6'd1
  };

  // serializer input: one finished code
  typedef struct packed {
    logic                           rej;
    logic [CodeLen-1:0][SymW-1:0]    sym;
    logic [CodeLen-1:0][LetterW-1:0] letter;
  } ser_in_t;

  // {found, position}, lowest matching slot wins
  function automatic logic [5:0] course_lookup(logic [5:0] id);
    logic [5:0] res;
    res = 6'd0;
    for (int k = 31; k >= 0; k--) begin
      if (COURSE_TAB[k] == id) begin
        res = {1'b1, 5'(k)};
      end
    end
    return res;
  endfunction

  // crc-16/xmodem update by one byte, msb first
  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [LetterW-1:0] letter_of(logic [SymW-1:0] s);
    logic [7:0] base;
    base = {~s, 3'b000};
    return SYM_LETTERS[base +: LetterW];
  endfunction

endpackage

// ===== hw/rtl/rce_intf.sv =====
// record code encoder channel interfaces: record input and code letter output
// depends on nothing; each carries valid, ready and the beat payload

interface rce_rec_if;
  logic        valid;
  logic        ready;
  logic [7:0]  minutes;
  logic [7:0]  seconds;
  logic [15:0] millis;
  logic [5:0]  course_code;
  logic [7:0]  driver;
  logic [7:0]  vehicle;
  logic [15:0] name_first;
  logic [15:0] name_second;

  modport source (
    output valid, minutes, seconds, millis, course_code, driver, vehicle,
           name_first, name_second,
    input  ready
  );
  modport sink (
    input  valid, minutes, seconds, millis, course_code, driver, vehicle,
           name_first, name_second,
    output ready
  );
endinterface

interface rce_code_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [3:0] position;
  logic [4:0] symbol;
  logic [6:0] letter;
  logic       last;

  modport source (
    output valid, ok, position, symbol, letter, last,
    input  ready
  );
  modport sink (
    input  valid, ok, position, symbol, letter, last,
    output ready
  );
endinterface

// ===== hw/rtl/rce_ser.sv =====
// record code encoder serializer: holds one code and sends it letter by letter
// depends on rce_pkg and the rce_code_if interface

module rce_ser import rce_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  ser_in_t in_data_i,
  output logic    in_ready_o,
  rce_code_if.source code_o
);

  logic       busy_q, busy_d;
  logic [3:0] cnt_q, cnt_d;
  ser_in_t    hold_q;
  logic       fire, last_beat, load;

  assign last_beat  = hold_q.rej | (cnt_q == 4'(CodeLen - 1));
  assign fire       = busy_q & code_o.ready;
  assign in_ready_o = ~busy_q | (fire & last_beat);
  assign load       = in_valid_i & in_ready_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = 4'd0;
    end else if (fire & last_beat) begin
      busy_d = 1'b0;
    end else if (fire) begin
      cnt_d = cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hold_q <= in_data_i;
    end
  end

  // a rejected record sends a single zeroed beat
  assign code_o.valid    = busy_q;
  assign code_o.ok       = ~hold_q.rej;
  assign code_o.position = hold_q.rej ? 4'd0 : cnt_q;
  assign code_o.symbol   = hold_q.rej ? '0 : hold_q.sym[cnt_q];
  assign code_o.letter   = hold_q.rej ? '0 : hold_q.letter[cnt_q];
  assign code_o.last     = last_beat;

endmodule

// ===== hw/rtl/record_code_encoder.sv =====
// record code encoder top level: seven-stage encode pipeline and letter serializer
// depends on rce_pkg, rce_rec_if / rce_code_if and rce_ser

// One record beat in, sixteen letter beats out (or one beat with ok low when the
// record is rejected: total time of 240000 ms or more, unknown course id, or
// character*37+kart of 512 or more). The record goes through seven register
// stages (products, sums, limit checks with the first crc bytes, three more crc
// stages of two bytes each, then the xor chain and letter mapping), and a new
// record may enter every cycle while the pipeline has room. The first letter is
// driven from the serializer's hold register, loaded from the seventh stage.
// Sustained rate is set by the output port: a valid code takes sixteen letter
// beats and a rejected one a single beat.

module record_code_encoder import rce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rce_rec_if.sink    rec_i,
  rce_code_if.source code_o
);

  // stage 1: products and course search
  typedef struct packed {
    logic [23:0] min_ms;
    logic [17:0] sec_ms;
    logic [15:0] millis;
    logic [4:0]  pos;
    logic        found;
    logic [13:0] drv_x;
    logic [7:0]  vehicle;
    logic [15:0] name_first;
    logic [15:0] name_second;
  } s1_t;

  // stage 2: total time and kart/character value
  typedef struct packed {
    logic [23:0] total;
    logic [13:0] kc;
    logic [4:0]  pos;
    logic        found;
    logic [15:0] name_first;
    logic [15:0] name_second;
  } s2_t;

  // stages 3 to 6: packed bytes and running crc
  typedef struct packed {
    logic        rej;
    logic [63:0] data;
    logic [15:0] crc;
  } crc_t;

  logic [7:1] v_q, v_d, v_in;
  logic [8:1] rdy;
  logic       ser_rdy;

  s1_t     s1_q, s1_d;
  s2_t     s2_q, s2_d;
  crc_t    crc_q [4];
  crc_t    crc_d [4];
  ser_in_t s7_q, s7_d;

  // stall chain: a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[8] = ser_rdy;
    for (int k = 7; k >= 1; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  assign rec_i.ready = rdy[1];
  assign v_in        = {v_q[6:1], rec_i.valid};
  assign v_d         = (rdy[7:1] & v_in) | (~rdy[7:1] & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // stage 1
  always_comb begin
    logic [5:0] look;
    look              = course_lookup(rec_i.course_code);
    s1_d.min_ms       = 24'(rec_i.minutes) * MS_PER_MIN;
    s1_d.sec_ms       = 18'(rec_i.seconds) * MS_PER_SEC;
    s1_d.millis       = rec_i.millis;
    s1_d.found        = look[5];
    s1_d.pos          = look[4:0];
    s1_d.drv_x        = 14'(rec_i.driver) * KART_MULT;
    s1_d.vehicle      = rec_i.vehicle;
    s1_d.name_first   = rec_i.name_first;
    s1_d.name_second  = rec_i.name_second;
  end

  // stage 2
  always_comb begin
    s2_d.total       = s1_q.min_ms + 24'(s1_q.sec_ms) + 24'(s1_q.millis);
    s2_d.kc          = s1_q.drv_x + 14'(s1_q.vehicle);
    s2_d.pos         = s1_q.pos;
    s2_d.found       = s1_q.found;
    s2_d.name_first  = s1_q.name_first;
    s2_d.name_second = s1_q.name_second;
  end

  // stage 3: limit checks, byte packing, crc over bytes 0 and 1
  always_comb begin
    logic [31:0] word;
    word = {s2_q.total[17:0], s2_q.pos, s2_q.kc[8:0]};
    crc_d[0].rej  = (s2_q.total >= TIME_LIMIT) | ~s2_q.found | (s2_q.kc >= KC_LIMIT);
    crc_d[0].data = {s2_q.name_second, s2_q.name_first, word};
    crc_d[0].crc  = crc_byte(crc_byte(16'h0000, word[7:0]), word[15:8]);
  end

  // stages 4 to 6: two more bytes each
  for (genvar j = 1; j < 4; j++) begin : g_crc
    always_comb begin
      crc_d[j]     = crc_q[j-1];
      crc_d[j].crc = crc_byte(crc_byte(crc_q[j-1].crc, crc_q[j-1].data[16*j +: 8]),
                              crc_q[j-1].data[16*j+8 +: 8]);
    end
  end

  // stage 7: xor chain from the last byte down, then 5-bit groups msb first
  always_comb begin
    logic [7:0]  key;
    logic [79:0] plain;
    logic [79:0] stream;
    plain = {crc_q[3].crc[7:0], crc_q[3].crc[15:8], crc_q[3].data};
    key   = XOR_SEED;
    for (int i = 9; i >= 0; i--) begin
      key                    = plain[8*i +: 8] ^ key;
      stream[79-8*i -: 8]    = key;
    end
    s7_d.rej = crc_q[3].rej;
    for (int k = 0; k < CodeLen; k++) begin
      s7_d.sym[k]    = stream[79-5*k -: 5];
      s7_d.letter[k] = letter_of(stream[79-5*k -: 5]);
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (rdy[1]) s1_q <= s1_d;
    if (rdy[2]) s2_q <= s2_d;
    if (rdy[3]) crc_q[0] <= crc_d[0];
    if (rdy[4]) crc_q[1] <= crc_d[1];
    if (rdy[5]) crc_q[2] <= crc_d[2];
    if (rdy[6]) crc_q[3] <= crc_d[3];
    if (rdy[7]) s7_q <= s7_d;
  end

  // letter serializer and output register
  rce_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v_q[7]),
    .in_data_i  (s7_q),
    .in_ready_o (ser_rdy),
    .code_o     (code_o)
  );

endmodule

// ===== dv/record_code_encoder_tb.sv =====
// testbench for record_code_encoder: directed and random records, letter-by-letter check
// depends on rce_pkg, the rce_rec_if / rce_code_if interfaces and the encoder top level
`timescale 1ns / 1ps

module record_code_encoder_tb;
  import rce_pkg::*;

  // no beat on either channel for this many cycles means the run is stuck
  localparam int unsigned HANG_LIMIT   = 2000;
  // quiet cycles after the last letter
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_RECORDS = 450;

  // own copies of the course id table and the letter alphabet
  localparam logic [5:0] COURSE_IDS [32] = '{
    6'd20, 6'd22, 6'd31, 6'd18, 6'd27, 6'd28, 6'd33, 6'd24,
    6'd30, 6'd17, 6'd25, 6'd19, 6'd34, 6'd26, 6'd32, 6'd29,
    6'd10, 6'd11, 6'd13, 6'd14, 6'd35, 6'd16, 6'd12, 6'd9,
    6'd15, 6'd36, 6'd37, 6'd38, 6'd39, 6'd23, 6'd40, 6'd1
  };
  localparam logic [255:0] ALPHABET = "S7LCX3JZE8FG4HBKWN52YPA6RTU9VMDQ";

  localparam logic [15:0] XMODEM_POLY = 16'h1021;
  localparam logic [7:0]  CHAIN_SEED  = 8'hC3;
  localparam int unsigned MAX_TOTAL_MS = 240000;
  localparam int unsigned MAX_KART_CODE = 512;
  localparam int unsigned KART_STEP  = 37;

  typedef struct packed {
    logic [7:0]  minutes;
    logic [7:0]  seconds;
    logic [15:0] millis;
    logic [5:0]  course_code;
    logic [7:0]  driver;
    logic [7:0]  vehicle;
    logic [15:0] name_first;
    logic [15:0] name_second;
  } record_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] position;
    logic [4:0] symbol;
    logic [6:0] letter;
    logic       last;
  } letter_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rce_rec_if  rec_bus ();
  rce_code_if code_bus ();

  record_code_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rec_i  (rec_bus),
    .code_o (code_bus)
  );

  // letters still owed by the block, oldest first
  letter_beat_t expected_letters [$];
  int unsigned  mismatch_count = 0;

  // remaining beats of a no-idle stretch, one per side
  int src_quiet = 0;
  int snk_quiet = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------

  // slot of a course id in the table, -1 when the id is unknown
  function automatic int course_slot(logic [5:0] id);
    int slot;
    slot = -1;
    for (int k = 0; k < 32; k++) begin
      if (slot < 0 && COURSE_IDS[k] == id) begin
        slot = k;
      end
    end
    return slot;
  endfunction

  // computes the letters one record should produce and queues them
  function automatic void encode_record(record_t r);
    int unsigned  total_ms;
    int unsigned  kart_code;
    int unsigned  packed_word;
    int           slot;
    logic [7:0]   code_bytes [10];
    logic [15:0]  crc;
    logic [7:0]   key;
    logic [79:0]  code_bits;
    letter_beat_t beat;
    total_ms  = r.millis + r.seconds * 1000 + r.minutes * 60000;
    kart_code = r.driver * KART_STEP + r.vehicle;
    slot      = course_slot(r.course_code);
    // any rejection gives a single all-zero beat marked last
    if (total_ms >= MAX_TOTAL_MS || slot < 0 || kart_code >= MAX_KART_CODE) begin
      beat = '0;
      beat.last = 1'b1;
      expected_letters.push_back(beat);
      return;
    end
    packed_word = (total_ms << 14) | (int'(slot) << 9) | kart_code;
    code_bytes[0] = packed_word[7:0];
    code_bytes[1] = packed_word[15:8];
    code_bytes[2] = packed_word[23:16];
    code_bytes[3] = packed_word[31:24];
    code_bytes[4] = r.name_first[7:0];
    code_bytes[5] = r.name_first[15:8];
    code_bytes[6] = r.name_second[7:0];
    code_bytes[7] = r.name_second[15:8];
    // crc-16/xmodem over the first eight bytes, stored big-endian
    crc = 16'h0000;
    for (int k = 0; k < 8; k++) begin
      crc = crc ^ {code_bytes[k], 8'h00};
      for (int b = 0; b < 8; b++) begin
        if (crc[15]) begin
          crc = {crc[14:0], 1'b0} ^ XMODEM_POLY;
        end else begin
          crc = {crc[14:0], 1'b0};
        end
      end
    end
    code_bytes[8] = crc[15:8];
    code_bytes[9] = crc[7:0];
    // xor chain from the top byte down, key follows the ciphertext
    key = CHAIN_SEED;
    for (int i = 9; i >= 0; i--) begin
      code_bytes[i] = code_bytes[i] ^ key;
      key = code_bytes[i];
    end
    code_bits = {code_bytes[0], code_bytes[1], code_bytes[2], code_bytes[3],
                 code_bytes[4], code_bytes[5], code_bytes[6], code_bytes[7],
                 code_bytes[8], code_bytes[9]};
    for (int k = 0; k < 16; k++) begin
      beat.ok       = 1'b1;
      beat.position = 4'(k);
      beat.symbol   = code_bits[79 - 5 * k -: 5];
      beat.letter   = ALPHABET[8 * (31 - int'(beat.symbol)) +: 7];
      beat.last     = (k == 15);
      expected_letters.push_back(beat);
    end
  endfunction

  // ------------------------------------------------------------------
  // idling
  // ------------------------------------------------------------------

  // wait before one beat: a random idle gap, with occasional no-idle stretches
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(15, 0) == 0) begin
      quiet_left = $urandom_range(40, 10);
      return 0;
    end
    return $urandom_range(11, 0);
  endfunction

  // ------------------------------------------------------------------
  // record sender
  // ------------------------------------------------------------------

  // presents one record, returns right after the edge that takes it
  task automatic send_record(input record_t r);
    int gap;
    gap = draw_wait(src_quiet);
    @(negedge clk_i);
    if (gap > 0) begin
      rec_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rec_bus.valid       <= 1'b1;
    rec_bus.minutes     <= r.minutes;
    rec_bus.seconds     <= r.seconds;
    rec_bus.millis      <= r.millis;
    rec_bus.course_code <= r.course_code;
    rec_bus.driver      <= r.driver;
    rec_bus.vehicle     <= r.vehicle;
    rec_bus.name_first  <= r.name_first;
    rec_bus.name_second <= r.name_second;
    do begin
      @(posedge clk_i);
    end while (!rec_bus.ready);
    encode_record(r);
  endtask

  // ------------------------------------------------------------------
  // letter checker
  // ------------------------------------------------------------------

  initial begin
    letter_beat_t want;
    letter_beat_t got;
    int stall;
    code_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(snk_quiet);
      @(negedge clk_i);
      if (stall > 0) begin
        code_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      code_bus.ready <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (!code_bus.valid);
      got = '{code_bus.ok, code_bus.position, code_bus.symbol, code_bus.letter,
              code_bus.last};
      if (expected_letters.size() == 0) begin
        $error("letter beat with nothing expected: ok %0h position %0h symbol %0h",
               got.ok, got.position, got.symbol);
        mismatch_count++;
      end else begin
        want = expected_letters.pop_front();
        if (got.ok !== want.ok) begin
          $error("ok: expected %0h actual %0h", want.ok, got.ok);
          mismatch_count++;
        end
        if (got.position !== want.position) begin
          $error("position: expected %0h actual %0h", want.position, got.position);
          mismatch_count++;
        end
        if (got.symbol !== want.symbol) begin
          $error("symbol: expected %0h actual %0h", want.symbol, got.symbol);
          mismatch_count++;
        end
        if (got.letter !== want.letter) begin
          $error("letter: expected %0h actual %0h", want.letter, got.letter);
          mismatch_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0h actual %0h", want.last, got.last);
          mismatch_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // watchdog: cycles with no beat on either channel
  // ------------------------------------------------------------------

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((rec_bus.valid && rec_bus.ready) || (code_bus.valid && code_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // total time around the 240000 ms limit and at each field's extreme
  task automatic test_time_limits();
    send_record('{8'd0, 8'd0, 16'd0, 6'd20, 8'd0, 8'd0, 16'h0000, 16'h0000});
    send_record('{8'd3, 8'd59, 16'd59999, 6'd20, 8'd1, 8'd2, 16'h0041, 16'h0042});
    send_record('{8'd3, 8'd59, 16'd60000, 6'd20, 8'd1, 8'd2, 16'h0041, 16'h0042});
    send_record('{8'd0, 8'd239, 16'd999, 6'd22, 8'd3, 8'd4, 16'hFFFF, 16'hFFFF});
    send_record('{8'd0, 8'd255, 16'd0, 6'd22, 8'd3, 8'd4, 16'hFFFF, 16'hFFFF});
    send_record('{8'd0, 8'd0, 16'd65535, 6'd31, 8'd5, 8'd6, 16'hAAAA, 16'h5555});
    send_record('{8'd255, 8'd0, 16'd0, 6'd31, 8'd5, 8'd6, 16'h5555, 16'hAAAA});
    send_record('{8'd255, 8'd255, 16'd65535, 6'd63, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF});
  endtask

  // last and largest table ids and id 9, plus ids that are not in the table
  task automatic test_course_lookup();
    send_record('{8'd1, 8'd2, 16'd3, 6'd1, 8'd7, 8'd8, 16'h1234, 16'h5678});
    send_record('{8'd1, 8'd2, 16'd3, 6'd40, 8'd7, 8'd8, 16'h1234, 16'h5678});
    send_record('{8'd1, 8'd2, 16'd3, 6'd9, 8'd7, 8'd8, 16'h1234, 16'h5678});
    send_record('{8'd1, 8'd2, 16'd3, 6'd0, 8'd7, 8'd8, 16'h1234, 16'h5678});
    send_record('{8'd1, 8'd2, 16'd3, 6'd2, 8'd7, 8'd8, 16'h1234, 16'h5678});
    send_record('{8'd1, 8'd2, 16'd3, 6'd41, 8'd7, 8'd8, 16'h1234, 16'h5678});
    send_record('{8'd1, 8'd2, 16'd3, 6'd63, 8'd7, 8'd8, 16'h1234, 16'h5678});
  endtask

  // character*37+kart around 512
  task automatic test_kart_limit();
    send_record('{8'd2, 8'd10, 16'd500, 6'd27, 8'd13, 8'd30, 16'h00FF, 16'hFF00});
    send_record('{8'd2, 8'd10, 16'd500, 6'd27, 8'd13, 8'd31, 16'h00FF, 16'hFF00});
    send_record('{8'd2, 8'd10, 16'd500, 6'd27, 8'd0, 8'd255, 16'h00FF, 16'hFF00});
    send_record('{8'd2, 8'd10, 16'd500, 6'd27, 8'd14, 8'd0, 16'h00FF, 16'hFF00});
    send_record('{8'd2, 8'd10, 16'd500, 6'd27, 8'd255, 8'd255, 16'h00FF, 16'hFF00});
  endtask

  // mostly well-formed records, some with one field pushed out of range, some noise
  task automatic test_random_records(input int unsigned count);
    record_t     r;
    int unsigned total_ms;
    int unsigned rest_ms;
    int unsigned sec_lo;
    int unsigned mins;
    int unsigned secs;
    int unsigned kart_hi;
    int unsigned flavor;
    for (int unsigned n = 0; n < count; n++) begin
      // well-formed base record with random content
      total_ms = $urandom_range(MAX_TOTAL_MS - 1, 0);
      mins     = $urandom_range(total_ms / 60000, 0);
      rest_ms  = total_ms - mins * 60000;
      sec_lo   = (rest_ms > 65535) ? (rest_ms - 65535 + 999) / 1000 : 0;
      secs     = $urandom_range(rest_ms / 1000, sec_lo);
      r.minutes     = 8'(mins);
      r.seconds     = 8'(secs);
      r.millis      = 16'(rest_ms - secs * 1000);
      r.course_code = COURSE_IDS[$urandom_range(31, 0)];
      r.driver      = 8'($urandom_range(13, 0));
      kart_hi       = 511 - r.driver * KART_STEP;
      r.vehicle     = 8'($urandom_range((kart_hi > 255) ? 255 : kart_hi, 0));
      r.name_first  = 16'($urandom);
      r.name_second = 16'($urandom);
      flavor = $urandom_range(99, 0);
      if (flavor >= 90) begin
        // noise: every field drawn over its whole range
        r = record_t'({$urandom, $urandom, $urandom});
      end else if (flavor >= 75) begin
        // one limit broken
        case ($urandom_range(2, 0))
          0: begin
            r.minutes = 8'($urandom_range(255, 4));
            r.seconds = 8'($urandom);
          end
          1: begin
            do begin
              r.course_code = 6'($urandom);
            end while (course_slot(r.course_code) >= 0);
          end
          default: begin
            r.driver  = 8'($urandom_range(255, 14));
            r.vehicle = 8'($urandom);
          end
        endcase
      end
      send_record(r);
    end
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------

  initial begin
    rst_ni              = 1'b0;
    rec_bus.valid       = 1'b0;
    rec_bus.minutes     = '0;
    rec_bus.seconds     = '0;
    rec_bus.millis      = '0;
    rec_bus.course_code = '0;
    rec_bus.driver      = '0;
    rec_bus.vehicle     = '0;
    rec_bus.name_first  = '0;
    rec_bus.name_second = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_time_limits();
    test_course_lookup();
    test_kart_limit();
    test_random_records(RANDOM_RECORDS);

    @(negedge clk_i);
    rec_bus.valid <= 1'b0;

    // drain owed letters, then watch a while for stray beats
    while (expected_letters.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
